@@ sv/dltq_pkg.sv @@
package dltq_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int ID_W          = 5;
   localparam int TIME_W        = 32;
   localparam int TICK_W        = 16;
   localparam logic [TICK_W-1:0] TICK_LEN_RST = 16'd10;

   localparam logic [1:0] MODE_CREATE   = 2'd0;
   localparam logic [1:0] MODE_DELETE   = 2'd1;
   localparam logic [1:0] MODE_TICK     = 2'd2;
   localparam logic [1:0] MODE_DISPATCH = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SLOT  = 2'd1;
   localparam logic [1:0] ST_NOT_QUED = 2'd2;
   localparam logic [1:0] ST_NONE_DUE = 2'd3;

   localparam logic [2:0] OP_HOLD           = 3'd0;
   localparam logic [2:0] OP_LOAD           = 3'd1;
   localparam logic [2:0] OP_FROM_LEFT      = 3'd2;
   localparam logic [2:0] OP_FROM_LEFT_SUB  = 3'd3;
   localparam logic [2:0] OP_FROM_RIGHT     = 3'd4;
   localparam logic [2:0] OP_FROM_RIGHT_ADD = 3'd5;
   localparam logic [2:0] OP_SET_DELTA      = 3'd6;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ID_W-1:0]   task_id;
      logic [TIME_W-1:0] delay_time;
      logic [TIME_W-1:0] period_time;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] result_id;
      logic            due_pending;
      logic [ID_W-1:0] active_count;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] delta;
      logic [TIME_W-1:0] period;
   } entry_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [TIME_W-1:0] arg;
   } cell_ctl_type;

endpackage

@@ sv/dltq_div.sv @@
module dltq_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic [dltq_pkg::TIME_W-1:0]       dividend,
   input  logic [dltq_pkg::TICK_W-1:0]       divisor,
   output logic                              done,
   output logic [dltq_pkg::TIME_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(dltq_pkg::TIME_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [dltq_pkg::TIME_W-1:0]   dvd_ff, dvd_in;
   logic [dltq_pkg::TICK_W-1:0]   rem_ff, rem_in;
   logic [dltq_pkg::TICK_W-1:0]   div_ff, div_in;
   logic [dltq_pkg::TICK_W:0]     trial;
   logic                          ge;

   assign trial = {rem_ff, dvd_ff[dltq_pkg::TIME_W-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? dltq_pkg::TICK_W'(trial - {1'b0, div_ff})
                     : trial[dltq_pkg::TICK_W-1:0];
         dvd_in = {dvd_ff[dltq_pkg::TIME_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(dltq_pkg::TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

@@ sv/dltq_cell.sv @@
module dltq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  dltq_pkg::cell_ctl_type ctl,
   input  dltq_pkg::entry_type    bus,
   input  dltq_pkg::entry_type    left,
   input  dltq_pkg::entry_type    right,
   output dltq_pkg::entry_type    q
);

   dltq_pkg::entry_type ent_ff, ent_in;

   always_comb begin
      ent_in = ent_ff;
      case (ctl.op)
         dltq_pkg::OP_HOLD: ent_in = ent_ff;
         dltq_pkg::OP_LOAD: ent_in = bus;
         dltq_pkg::OP_FROM_LEFT: ent_in = left;
         dltq_pkg::OP_FROM_LEFT_SUB: begin
            ent_in       = left;
            ent_in.delta = left.delta - ctl.arg;
         end
         dltq_pkg::OP_FROM_RIGHT: ent_in = right;
         dltq_pkg::OP_FROM_RIGHT_ADD: begin
            ent_in       = right;
            ent_in.delta = right.delta + ent_ff.delta;
         end
         dltq_pkg::OP_SET_DELTA: ent_in.delta = ctl.arg;
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
      ent_ff.id     <= ent_in.id;
      ent_ff.delta  <= ent_in.delta;
      ent_ff.period <= ent_in.period;
   end

   assign q = ent_ff;

endmodule

@@ sv/delta_list_task_timer_queue_top.sv @@
// Timer queue of up to MAX_TASKS task slots, kept as a sorted delta list in a row of cells.
// Command channel: a transaction is taken when start is high and busy is low; req_payload
// carries mode, task_id, delay_time and period_time. Busy stays high until the result.
// Result channel: rsp_valid is high for exactly one cycle with rsp_payload; the receiver
// cannot stall it, so the block never waits on the output side.
// Tick, one-shot dispatch and commands refused at once go straight to the result; delete
// first walks the list to the slot; dispatch of a periodic task walks to its new place; create
// first runs the bit-serial divider (one quotient bit per cycle) and then the
// one-cell-per-cycle list walk to the insertion position.
// One transaction at a time; the next is taken the cycle after the result strobe.
// csr_we writes tick_length (0 divides as 1); write only while busy is low.
// Reset (synchronous, active high) empties the queue, refills the free list with slots
// 1..MAX_TASKS in order, clears the skip count and sets tick_length to 10.
module delta_list_task_timer_queue_top #(
   parameter int MAX_TASKS = dltq_pkg::MAX_TASKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  dltq_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   output dltq_pkg::rsp_type             rsp_payload,
   input  logic                          csr_we,
   input  logic [dltq_pkg::TICK_W-1:0]   csr_wdata
);

   localparam int KW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int IW = dltq_pkg::ID_W;
   localparam int TW = dltq_pkg::TIME_W;
   localparam int SW = dltq_pkg::TICK_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_INS  = 3'd2;
   localparam logic [2:0] S_DEL  = 3'd3;
   localparam logic [2:0] S_RSP  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [TW-1:0]    rem_ff, rem_in;
   logic [IW-1:0]    nid_ff, nid_in;
   logic [TW-1:0]    nper_ff, nper_in;
   logic [IW-1:0]    tid_ff, tid_in;
   logic [1:0]       status_ff, status_in;
   logic [IW-1:0]    rid_ff, rid_in;
   logic [SW-1:0]    skip_ff, skip_in;
   logic [SW-1:0]    tlen_ff;
   logic [IW-1:0]    freeq_ff [MAX_TASKS];
   logic [KW-1:0]    frd_ff, frd_in;
   logic [KW-1:0]    fwr_ff, fwr_in;
   logic [CW-1:0]    fcnt_ff, fcnt_in;
   logic             push;
   logic [IW-1:0]    push_id;

   dltq_pkg::entry_type    cell_q   [MAX_TASKS];
   dltq_pkg::cell_ctl_type cell_ctl [MAX_TASKS];
   dltq_pkg::entry_type    bus;
   dltq_pkg::entry_type    empty;
   dltq_pkg::entry_type    cur;
   dltq_pkg::entry_type    head;

   logic             div_go;
   logic [SW-1:0]    divisor;
   logic             dd_done, dp_done;
   logic [TW-1:0]    dd_q, dp_q;
   logic [TW:0]      dsum;
   logic [SW-1:0]    s1;

   assign empty   = '0;
   assign cur     = cell_q[k_ff];
   assign head    = cell_q[0];
   assign divisor = (tlen_ff == '0) ? SW'(1) : tlen_ff;
   assign dsum    = {1'b0, dd_q} + {{(TW+1-SW){1'b0}}, skip_ff};
   assign s1      = (skip_ff == {SW{1'b1}}) ? skip_ff : skip_ff + 1'b1;

   dltq_div u_div_delay (
      .clock(clock), .reset(reset), .go(div_go), .dividend(req_payload.delay_time),
      .divisor(divisor), .done(dd_done), .quotient(dd_q)
   );

   dltq_div u_div_period (
      .clock(clock), .reset(reset), .go(div_go), .dividend(req_payload.period_time),
      .divisor(divisor), .done(dp_done), .quotient(dp_q)
   );

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      dltq_cell u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(cell_ctl[g]),
         .bus(bus),
         .left((g == 0) ? empty : cell_q[(g == 0) ? 0 : g-1]),
         .right((g == MAX_TASKS-1) ? empty : cell_q[(g == MAX_TASKS-1) ? g : g+1]),
         .q(cell_q[g])
      );
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      rem_in    = rem_ff;
      nid_in    = nid_ff;
      nper_in   = nper_ff;
      tid_in    = tid_ff;
      status_in = status_ff;
      rid_in    = rid_ff;
      skip_in   = skip_ff;
      frd_in    = frd_ff;
      fcnt_in   = fcnt_ff;
      push      = 1'b0;
      push_id   = '0;
      div_go    = 1'b0;
      bus       = '{valid: 1'b1, id: nid_ff, delta: rem_ff, period: nper_ff};
      for (int i = 0; i < MAX_TASKS; i++) begin
         cell_ctl[i] = '{op: dltq_pkg::OP_HOLD, arg: rem_ff};
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = dltq_pkg::ST_OK;
               rid_in    = '0;
               state_in  = S_RSP;
               case (req_payload.mode)
                  dltq_pkg::MODE_CREATE: begin
                     if (fcnt_ff == '0) begin
                        status_in = dltq_pkg::ST_NO_SLOT;
                     end else begin
                        nid_in   = freeq_ff[frd_ff];
                        rid_in   = freeq_ff[frd_ff];
                        frd_in   = (frd_ff == KW'(MAX_TASKS-1)) ? '0 : frd_ff + 1'b1;
                        fcnt_in  = fcnt_ff - 1'b1;
                        div_go   = 1'b1;
                        state_in = S_DIV;
                     end
                  end
                  dltq_pkg::MODE_DELETE: begin
                     if (req_payload.task_id == '0 ||
                         req_payload.task_id > IW'(MAX_TASKS)) begin
                        status_in = dltq_pkg::ST_NOT_QUED;
                     end else begin
                        tid_in   = req_payload.task_id;
                        k_in     = '0;
                        state_in = S_DEL;
                     end
                  end
                  dltq_pkg::MODE_TICK: begin
                     if (!head.valid) begin
                        skip_in = (fcnt_ff != CW'(MAX_TASKS)) ? s1 : '0;
                     end else if (head.delta == '0) begin
                        skip_in = s1;
                     end else if (head.delta >= {{(TW-SW){1'b0}}, s1}) begin
                        skip_in     = '0;
                        cell_ctl[0] = '{op: dltq_pkg::OP_SET_DELTA,
                                        arg: head.delta - {{(TW-SW){1'b0}}, s1}};
                     end else begin
                        skip_in     = s1 - head.delta[SW-1:0];
                        cell_ctl[0] = '{op: dltq_pkg::OP_SET_DELTA, arg: '0};
                     end
                  end
                  dltq_pkg::MODE_DISPATCH: begin
                     if (!head.valid || head.delta != '0) begin
                        status_in = dltq_pkg::ST_NONE_DUE;
                     end else begin
                        rid_in = head.id;
                        for (int i = 0; i < MAX_TASKS; i++) begin
                           cell_ctl[i].op = dltq_pkg::OP_FROM_RIGHT;
                        end
                        if (head.period != '0) begin
                           nid_in   = head.id;
                           nper_in  = head.period;
                           rem_in   = head.period;
                           k_in     = '0;
                           state_in = S_INS;
                        end else begin
                           push    = 1'b1;
                           push_id = head.id;
                        end
                     end
                  end
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_DIV: begin
            if (dd_done && dp_done) begin
               rem_in   = dsum[TW] ? {TW{1'b1}} : dsum[TW-1:0];
               nper_in  = dp_q;
               k_in     = '0;
               state_in = S_INS;
            end
         end
         S_INS: begin
            if (cur.valid && cur.delta > rem_ff) begin
               for (int i = 0; i < MAX_TASKS; i++) begin
                  if (KW'(i) == k_ff) begin
                     cell_ctl[i].op = dltq_pkg::OP_LOAD;
                  end else if ((KW+1)'(i) == {1'b0, k_ff} + 1'b1) begin
                     cell_ctl[i].op = dltq_pkg::OP_FROM_LEFT_SUB;
                  end else if (KW'(i) > k_ff) begin
                     cell_ctl[i].op = dltq_pkg::OP_FROM_LEFT;
                  end
               end
               state_in = S_RSP;
            end else if (cur.valid) begin
               rem_in = rem_ff - cur.delta;
               k_in   = k_ff + 1'b1;
            end else begin
               for (int i = 0; i < MAX_TASKS; i++) begin
                  if (KW'(i) == k_ff) begin
                     cell_ctl[i].op = dltq_pkg::OP_LOAD;
                  end
               end
               state_in = S_RSP;
            end
         end
         S_DEL: begin
            if (cur.valid && cur.id == tid_ff) begin
               for (int i = 0; i < MAX_TASKS; i++) begin
                  if (KW'(i) == k_ff) begin
                     cell_ctl[i].op = dltq_pkg::OP_FROM_RIGHT_ADD;
                  end else if (KW'(i) > k_ff) begin
                     cell_ctl[i].op = dltq_pkg::OP_FROM_RIGHT;
                  end
               end
               push     = 1'b1;
               push_id  = tid_ff;
               state_in = S_RSP;
            end else if (!cur.valid || k_ff == KW'(MAX_TASKS-1)) begin
               status_in = dltq_pkg::ST_NOT_QUED;
               state_in  = S_RSP;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_RSP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase

      fwr_in = fwr_ff;
      if (push) begin
         fwr_in  = (fwr_ff == KW'(MAX_TASKS-1)) ? '0 : fwr_ff + 1'b1;
         fcnt_in = fcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         skip_ff  <= '0;
         tlen_ff  <= dltq_pkg::TICK_LEN_RST;
         frd_ff   <= '0;
         fwr_ff   <= '0;
         fcnt_ff  <= CW'(MAX_TASKS);
         for (int i = 0; i < MAX_TASKS; i++) begin
            freeq_ff[i] <= IW'(i + 1);
         end
      end else begin
         state_ff <= state_in;
         skip_ff  <= skip_in;
         frd_ff   <= frd_in;
         fwr_ff   <= fwr_in;
         fcnt_ff  <= fcnt_in;
         if (csr_we) begin
            tlen_ff <= csr_wdata;
         end
         if (push) begin
            freeq_ff[fwr_ff] <= push_id;
         end
      end
      k_ff      <= k_in;
      rem_ff    <= rem_in;
      nid_ff    <= nid_in;
      nper_ff   <= nper_in;
      tid_ff    <= tid_in;
      status_ff <= status_in;
      rid_ff    <= rid_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_payload.status       = status_ff;
   assign rsp_payload.result_id    = rid_ff;
   assign rsp_payload.due_pending  = head.valid && (head.delta == '0);
   assign rsp_payload.active_count = IW'(CW'(MAX_TASKS) - fcnt_ff);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transaction taken without going busy");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= CW'(MAX_TASKS))
      else $error("free list count out of range");

   a_compact: assert property (@(posedge clock) disable iff (reset)
      !cell_q[0].valid |-> !cell_q[MAX_TASKS-1].valid)
      else $error("queue cells not compacted");

endmodule
